### hw/rtl/vss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vss_pkg
// Types and constants shared by the version string scanner.
// ----------------------------------------------------------------------------
package vss_pkg;

    localparam int unsigned POS_W = 4;

    // match positions with special meaning
    localparam logic [POS_W-1:0] POS_MAJOR = 4'd0;
    localparam logic [POS_W-1:0] POS_DOT1  = 4'd1;
    localparam logic [POS_W-1:0] POS_DOT2  = 4'd5;
    localparam logic [POS_W-1:0] POS_END   = 4'd9;

    // last minor digit position
    localparam logic [POS_W-1:0] POS_MINOR_LAST = 4'd4;

    localparam logic [7:0] CHAR_DOT   = 8'h2e;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_Z  = 8'h5a;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_Z  = 8'h7a;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic       found;
        logic [3:0] major;
        logic [9:0] minor;
        logic [9:0] patch;
    } out_item_t;

endpackage : vss_pkg
`default_nettype wire

### hw/rtl/version_string_scanner_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// version_string_scanner_core
// Scans a byte stream for a version string d.ddd.ddd and reports it.
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one stream byte per transaction (data_byte, last_byte)
//   m_ channel: at most one result per input transaction
//     found=1 with major/minor/patch when a digit-only candidate is
//     terminated, found=0 with zero fields when the stream ends unmatched
//   one byte per cycle sustained while m_ready stays high; the scan state update is a compare and a
//   decimal multiply-by-ten accumulate, done in the accept cycle
//   a result is registered and is valid on m_ the cycle after its byte is accepted
//   after a version is reported every further byte is accepted and dropped
//   until reset
//   reset (aresetn low, synchronous) clears the scan state, the done flag
//   and the output valid
//   when the receiver stalls with a result held, s_ready drops until the
//   result is taken; s_ready is high again in the cycle m_ready is high,
//   so the output register never blocks back-to-back transfers
// ----------------------------------------------------------------------------
module version_string_scanner_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire vss_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output vss_pkg::out_item_t      m_data
);
    import vss_pkg::*;

    // scan state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [3:0]       major_reg, major_next;
    logic [9:0]       minor_reg, minor_next;
    logic [9:0]       patch_reg, patch_next;
    logic             all_digits_reg, all_digits_next;
    logic             done_reg, done_next;

    // output register
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg, m_data_next;

    logic             accept;
    logic             is_digit;
    logic             is_alnum;
    logic             is_dot;
    logic [3:0]       digit_val;
    logic [13:0]      minor_acc_sum;
    logic [13:0]      patch_acc_sum;
    logic             emit;
    out_item_t        result;

    // output register frees up when empty or being drained
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // byte classification
    always_comb begin
        is_digit  = (s_data.data_byte >= CHAR_0) && (s_data.data_byte <= CHAR_9);
        is_alnum  = is_digit
                 || ((s_data.data_byte >= CHAR_UC_A) && (s_data.data_byte <= CHAR_UC_Z))
                 || ((s_data.data_byte >= CHAR_LC_A) && (s_data.data_byte <= CHAR_LC_Z));
        is_dot    = (s_data.data_byte == CHAR_DOT);
        digit_val = is_digit ? 4'(s_data.data_byte - CHAR_0) : 4'd0;
        // x*10 + d as shifts and adds
        minor_acc_sum = {1'b0, minor_reg, 3'b000} + {3'b000, minor_reg, 1'b0}
                      + {10'd0, digit_val};
        patch_acc_sum = {1'b0, patch_reg, 3'b000} + {3'b000, patch_reg, 1'b0}
                      + {10'd0, digit_val};
    end

    // scan step
    always_comb begin
        pos_next        = pos_reg;
        major_next      = major_reg;
        minor_next      = minor_reg;
        patch_next      = patch_reg;
        all_digits_next = all_digits_reg;
        done_next       = done_reg;
        emit            = 1'b0;
        result          = '0;

        if (accept && !done_reg) begin
            if (is_alnum && (pos_reg != POS_DOT1) && (pos_reg != POS_DOT2)
                    && (pos_reg < POS_END)) begin
                if (pos_reg == POS_MAJOR) begin
                    // first character opens a new candidate
                    major_next      = digit_val;
                    minor_next      = '0;
                    patch_next      = '0;
                    all_digits_next = is_digit;
                end else if (!is_digit) begin
                    all_digits_next = 1'b0;
                end else if (pos_reg <= POS_MINOR_LAST) begin
                    minor_next = minor_acc_sum[9:0];
                end else begin
                    patch_next = patch_acc_sum[9:0];
                end
                pos_next = pos_reg + POS_W'(1);
            end else if (is_dot && ((pos_reg == POS_DOT1) || (pos_reg == POS_DOT2))) begin
                pos_next = pos_reg + POS_W'(1);
            end else if (!is_alnum && !is_dot && (pos_reg == POS_END) && all_digits_reg) begin
                // terminated digit-only candidate: report and stop
                done_next    = 1'b1;
                emit         = 1'b1;
                result.found = 1'b1;
                result.major = major_reg;
                result.minor = minor_reg;
                result.patch = patch_reg;
            end else begin
                pos_next = '0;
            end

            // end of stream without a match
            if (!done_next && s_data.last_byte) begin
                emit            = 1'b1;
                result          = '0;
                pos_next        = '0;
                major_next      = '0;
                minor_next      = '0;
                patch_next      = '0;
                all_digits_next = 1'b1;
            end
        end
    end

    // output register next value
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            major_reg      <= '0;
            minor_reg      <= '0;
            patch_reg      <= '0;
            all_digits_reg <= 1'b1;
            done_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            major_reg      <= major_next;
            minor_reg      <= minor_next;
            patch_reg      <= patch_next;
            all_digits_reg <= all_digits_next;
            done_reg       <= done_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload register, no reset
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule : version_string_scanner_core
`default_nettype wire

### tb/sv/version_string_scanner_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// version_string_scanner_core_test
// Self-checking bench for the version string scanner. A byte-level model of
// the scan tracks every accepted byte and queues the results it implies. Each
// result the core hands out is compared field by field with the oldest one.
// The stream keeps every candidate short of a report until the very end,
// because a report freezes the core until reset. The run closes with one
// real version on the final byte, followed by bytes that must be dropped.
// ----------------------------------------------------------------------------
module version_string_scanner_core_test;

    import vss_pkg::*;

    localparam int RANDOM_BYTES = 1350;   // rough size of the random stream
    localparam int STALL_LIMIT = 4000;    // cycles without any transaction
    localparam int MAX_SHOWN = 10;        // mismatches printed in full

    // ------------------------------------------------------------------------
    // scan model and result checker
    // ------------------------------------------------------------------------
    class version_scan_checker;
        logic [3:0] pos;
        logic [3:0] major_acc;
        logic [9:0] minor_acc;
        logic [9:0] patch_acc;
        bit         all_digits;
        bit         done;
        out_item_t  scan_results_due[$];
        out_item_t  reported_version;
        int         failures;
        int         unmatched_ends;
        int         versions_found;

        function new();
            clear_scan();
            done = 1'b0;
            failures = 0;
            unmatched_ends = 0;
            versions_found = 0;
            reported_version = '0;
        endfunction

        function void clear_scan();
            pos = POS_MAJOR;
            major_acc = '0;
            minor_acc = '0;
            patch_acc = '0;
            all_digits = 1'b1;
        endfunction

        function bit is_digit(logic [7:0] b);
            return b >= CHAR_0 && b <= CHAR_9;
        endfunction

        function bit is_alnum(logic [7:0] b);
            return is_digit(b) || (b >= CHAR_UC_A && b <= CHAR_UC_Z)
                || (b >= CHAR_LC_A && b <= CHAR_LC_Z);
        endfunction

        // true when this byte, taken now, would finish a reportable version
        function bit would_report(logic [7:0] b);
            return !done && pos == POS_END && all_digits && !is_alnum(b)
                && b != CHAR_DOT;
        endfunction

        // advance the scan by one accepted byte, queue what it implies
        function void scan_byte(in_item_t item);
            logic [7:0] b;
            logic [3:0] d;
            bit         dig;
            bit         aln;
            out_item_t  res;
            b = item.data_byte;
            dig = is_digit(b);
            aln = is_alnum(b);
            d = dig ? 4'(b - CHAR_0) : 4'd0;
            if (done) return;
            if (aln && pos != POS_DOT1 && pos != POS_DOT2 && pos < POS_END) begin
                if (pos == POS_MAJOR) begin
                    major_acc = d;
                    minor_acc = '0;
                    patch_acc = '0;
                    all_digits = dig;
                end else if (!dig) begin
                    all_digits = 1'b0;
                end else if (pos <= POS_MINOR_LAST) begin
                    minor_acc = 10'(minor_acc * 10 + d);
                end else begin
                    patch_acc = 10'(patch_acc * 10 + d);
                end
                pos = pos + 4'd1;
            end else if (b == CHAR_DOT && (pos == POS_DOT1 || pos == POS_DOT2)) begin
                pos = pos + 4'd1;
            end else if (!aln && b != CHAR_DOT && pos == POS_END && all_digits) begin
                // a version on the final byte gives this result only
                done = 1'b1;
                res.found = 1'b1;
                res.major = major_acc;
                res.minor = minor_acc;
                res.patch = patch_acc;
                scan_results_due.push_back(res);
                return;
            end else begin
                pos = POS_MAJOR;
            end
            if (item.last_byte) begin
                res = '0;
                scan_results_due.push_back(res);
                clear_scan();
            end
        endfunction

        function void check_scan_result(out_item_t got);
            out_item_t want;
            if (scan_results_due.size() == 0) begin
                failures++;
                if (failures <= MAX_SHOWN)
                    $display("unexpected result: found=%0d major=%0d minor=%0d patch=%0d",
                             got.found, got.major, got.minor, got.patch);
                return;
            end
            want = scan_results_due.pop_front();
            if (got.found !== want.found || got.major !== want.major
                    || got.minor !== want.minor || got.patch !== want.patch) begin
                failures++;
                if (failures <= MAX_SHOWN)
                    $display("result mismatch: expected found=%0d %0d.%0d.%0d, got found=%0d %0d.%0d.%0d",
                             want.found, want.major, want.minor, want.patch,
                             got.found, got.major, got.minor, got.patch);
            end
            if (want.found) begin
                versions_found++;
                reported_version = want;
            end else begin
                unmatched_ends++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and the core
    // ------------------------------------------------------------------------
    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    version_scan_checker scan_check = new();

    bit steady = 1'b0;        // no idling on either side while set
    bit allow_report = 1'b0;  // only the closing version may be reported
    int bytes_sent = 0;
    int bytes_dropped = 0;
    int idle_cycles = 0;

    always #5 aclk = ~aclk;

    version_string_scanner_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // ------------------------------------------------------------------------
    // result side: random back-pressure, every accepted result is checked
    // values read here are the ones settled before the edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            scan_check.check_scan_result(m_data);
        m_ready <= steady || ($urandom_range(0, 99) >= 11);
    end

    // watchdog: ends a run in which nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("no transaction for %0d cycles, giving up", STALL_LIMIT);
            $display("version_string_scanner_core_test: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // byte pickers
    // ------------------------------------------------------------------------
    function automatic logic [7:0] digit_char();
        return CHAR_0 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] letter_char();
        int n;
        n = $urandom_range(0, 51);
        return (n < 26) ? CHAR_UC_A + 8'(n) : CHAR_LC_A + 8'(n - 26);
    endfunction

    // byte that is neither alphanumeric nor a dot, i.e. a terminator
    function automatic logic [7:0] term_char();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (scan_check.is_alnum(b) || b == CHAR_DOT)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic logic random_last();
        return $urandom_range(0, 99) < 4;
    endfunction

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    // one transaction on s_, with random idle cycles in front of it; before
    // the closing phase a byte that would finish a version becomes a letter,
    // so the core stays live for the whole stream
    task automatic send_byte(input logic [7:0] b, input logic last_b);
        in_item_t item;
        if (!allow_report && scan_check.would_report(b))
            b = letter_char();
        item.data_byte = b;
        item.last_byte = last_b;
        while (!steady && $urandom_range(0, 99) < 11) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (scan_check.done) bytes_dropped++;
        scan_check.scan_byte(item);
        bytes_sent++;
    endtask

    task automatic send_string(input string text, input logic last_at_end);
        int i;
        for (i = 0; i < text.len(); i++)
            send_byte(text[i], last_at_end && i == text.len() - 1);
    endtask

    // full d.ddd.ddd shape with mostly digits, then a closing byte
    task automatic send_candidate();
        logic [7:0] ch;
        bit         clean;
        int         i;
        clean = 1'b1;
        for (i = 0; i < 9; i++) begin
            if (i == 1 || i == 5) begin
                ch = CHAR_DOT;
            end else if ($urandom_range(0, 99) < 8) begin
                ch = letter_char();
                clean = 1'b0;
            end else begin
                ch = digit_char();
            end
            send_byte(ch, random_last());
        end
        // digit-only shapes close on a dot or alphanumeric, others mostly on a terminator
        if (clean || $urandom_range(0, 3) == 0)
            ch = $urandom_range(0, 1) ? CHAR_DOT
                 : ($urandom_range(0, 1) ? digit_char() : letter_char());
        else
            ch = term_char();
        send_byte(ch, random_last());
    endtask

    // a prefix of the shape, broken by an arbitrary byte
    task automatic send_broken();
        int k;
        int i;
        k = $urandom_range(1, 8);
        for (i = 0; i < k; i++)
            send_byte((i == 1 || i == 5) ? CHAR_DOT : digit_char(), random_last());
        send_byte(8'($urandom_range(0, 255)), random_last());
    endtask

    task automatic send_noise();
        int n;
        int i;
        int pick;
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) begin
            pick = $urandom_range(0, 3);
            send_byte(pick == 0 ? digit_char() : pick == 1 ? CHAR_DOT
                      : 8'($urandom_range(0, 255)), random_last());
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        int         random_sent;
        int         kind;
        int         mode;
        int         i;
        logic [7:0] ver[7];

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // candidate with letters among the digits, failed on a 0xff terminator
        send_string("0.000.Zz9", 1'b0);
        send_byte(8'hff, 1'b0);
        // letter as major, then an alphanumeric where the dot belongs; the
        // breaking byte is not taken as a new start
        send_string("a1", 1'b0);
        // stream ends unmatched on a zero byte
        send_byte(8'h00, 1'b1);
        // digit-only shape whose closing byte is a dot: no report
        send_string("9.999.999.", 1'b0);
        // new stream starts on a letter and ends right away
        send_string("A", 1'b1);

        // random stream, mostly well-formed shapes with random content
        random_sent = 0;
        while (random_sent < RANDOM_BYTES) begin
            steady = (random_sent >= 500 && random_sent < 800);
            kind = $urandom_range(0, 99);
            i = bytes_sent;
            if (kind < 55)
                send_candidate();
            else if (kind < 75)
                send_broken();
            else
                send_noise();
            random_sent += bytes_sent - i;
        end
        steady = 1'b0;

        // closing version on the final byte; a space first puts the scan at
        // the start of the shape whatever state it was left in
        send_byte(8'h20, 1'b0);
        allow_report = 1'b1;
        mode = $urandom_range(0, 2);
        for (i = 0; i < 7; i++)
            ver[i] = (mode == 0) ? CHAR_0 : (mode == 1) ? CHAR_9 : digit_char();
        send_byte(ver[0], 1'b0);
        send_byte(CHAR_DOT, 1'b0);
        for (i = 1; i < 4; i++) send_byte(ver[i], 1'b0);
        send_byte(CHAR_DOT, 1'b0);
        for (i = 4; i < 7; i++) send_byte(ver[i], 1'b0);
        send_byte(term_char(), 1'b1);

        // after the report everything is dropped, a final-byte mark included
        for (i = 0; i < 12; i++)
            send_byte(8'($urandom_range(0, 255)), i == 5 || random_last());
        s_valid <= 1'b0;

        while (scan_check.scan_results_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("stream of %0d bytes (%0d dropped after the report): %0d unmatched ends",
                 bytes_sent, bytes_dropped, scan_check.unmatched_ends);
        $display("%0d version report(s), last %0d.%0d.%0d; %0d mismatch(es)",
                 scan_check.versions_found, scan_check.reported_version.major,
                 scan_check.reported_version.minor, scan_check.reported_version.patch,
                 scan_check.failures);
        if (scan_check.failures == 0 && scan_check.scan_results_due.size() == 0) begin
            $display("version_string_scanner_core_test: PASS");
        end else begin
            $display("version_string_scanner_core_test: FAIL");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/vss_pkg.sv
hw/rtl/version_string_scanner_core.sv
tb/sv/version_string_scanner_core_test.sv
